/* rtl/tqrb_pkg.sv */
`default_nettype none

package tqrb_pkg;

    localparam int QUEUE_DEPTH = 6;
    localparam int BODY_WIDTH  = 32;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = 16;
    localparam int TYPE_W  = 8;
    localparam int MSG_W   = 32;
    localparam int SEED_W  = 4;
    localparam int LCG_W   = 31;
    localparam int BO_W    = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [LCG_W-1:0] LCG_MUL = 31'd1103515245;
    localparam logic [LCG_W-1:0] LCG_ADD = 31'd12345;

    localparam logic REG_SEED = 1'b0;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [LEVEL_W-1:0]    level_t;
    typedef logic [BODY_WIDTH-1:0] body_t;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DONE    = 2'd1,
        CMD_TICK    = 2'd2
    } cmd_code_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    function automatic idx_t next_index(input idx_t idx);
        idx_t res;
        if (idx == IDX_W'(QUEUE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/tx_queue_random_backoff_top.sv */
`default_nettype none

// Transmit queue with random backoff. Each request carries a command: enqueue stores
// a message in a six-entry circular queue (dropped when full), transmission done frees
// the head entry and toggles the LED, and a timer tick counts the backoff down; done and
// tick start a send of the head message when nothing is pending and the backoff is zero,
// stepping a 31-bit LCG whose bits 6:5 give the next backoff. Every request gives
// exactly one result. A request is accepted in the idle state; the execute state then
// holds the queue update and the LCG multiply; the result sits in an output register,
// and, back in idle, the next request is taken once that register is free or being
// read. Writing backoff_seed (byte address 0) loads the LCG; configure only while idle.
module tx_queue_random_backoff_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tqrb_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [tqrb_pkg::PDATA_W-1:0]    pwdata,
    output logic [tqrb_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      command,
    input  wire logic [tqrb_pkg::ADDR_W-1:0]     msg_addr,
    input  wire logic [tqrb_pkg::TYPE_W-1:0]     msg_type,
    input  wire logic [tqrb_pkg::MSG_W-1:0]      msg_body,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 send_valid,
    output logic [tqrb_pkg::ADDR_W-1:0]          send_addr,
    output logic [tqrb_pkg::TYPE_W-1:0]          send_type,
    output logic [tqrb_pkg::MSG_W-1:0]           send_body,
    output logic                                 enqueue_accepted,
    output logic [tqrb_pkg::LEVEL_W-1:0]         queue_level,
    output logic                                 led_on
);

    tqrb_pkg::dp_cmd_t               dp_cmd;
    logic                            seed_sel;
    logic                            seed_we;
    logic [tqrb_pkg::SEED_W-1:0]     seed;

    assign pready   = 1'b1;
    assign seed_sel = (paddr[tqrb_pkg::PADDR_W-1:2] == tqrb_pkg::REG_SEED);
    assign seed_we  = psel && penable && pwrite && pready && seed_sel;
    assign prdata   = seed_sel ? tqrb_pkg::PDATA_W'(seed) : '0;

    tqrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd)
    );

    tqrb_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .dp_cmd           (dp_cmd),
        .command          (command),
        .msg_addr         (msg_addr),
        .msg_type         (msg_type),
        .msg_body         (msg_body),
        .seed_we          (seed_we),
        .seed_wdata       (pwdata[tqrb_pkg::SEED_W-1:0]),
        .seed             (seed),
        .send_valid       (send_valid),
        .send_addr        (send_addr),
        .send_type        (send_type),
        .send_body        (send_body),
        .enqueue_accepted (enqueue_accepted),
        .queue_level      (queue_level),
        .led_on           (led_on)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> queue_level <= tqrb_pkg::LEVEL_W'(tqrb_pkg::QUEUE_DEPTH))
        else $error("queue level above depth");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !send_valid) |-> (send_addr == '0 && send_type == '0 && send_body == '0))
        else $error("send fields not cleared without a send");

    a_send_or_enq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(send_valid && enqueue_accepted))
        else $error("send and enqueue in one result");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && out_valid == $past(out_valid && !out_ready)))
        else $error("request accepted while another is in flight");

endmodule

`default_nettype wire

/* rtl/tqrb_ctrl.sv */
`default_nettype none

module tqrb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output tqrb_pkg::dp_cmd_t     dp_cmd
);

    tqrb_pkg::state_t state_reg;
    tqrb_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tqrb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        dp_cmd         = '0;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            tqrb_pkg::ST_IDLE:
            begin
                in_ready       = !out_valid_reg || out_ready;
                dp_cmd.capture = in_valid && in_ready;
                if (dp_cmd.capture)
                begin
                    state_next = tqrb_pkg::ST_EXEC;
                end
            end
            tqrb_pkg::ST_EXEC:
            begin
                dp_cmd.execute = 1'b1;
                out_valid_next = 1'b1;
                state_next     = tqrb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tqrb_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/tqrb_dp.sv */
`default_nettype none

module tqrb_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tqrb_pkg::dp_cmd_t               dp_cmd,
    input  wire logic [1:0]                      command,
    input  wire logic [tqrb_pkg::ADDR_W-1:0]     msg_addr,
    input  wire logic [tqrb_pkg::TYPE_W-1:0]     msg_type,
    input  wire logic [tqrb_pkg::MSG_W-1:0]      msg_body,
    input  wire logic                            seed_we,
    input  wire logic [tqrb_pkg::SEED_W-1:0]     seed_wdata,
    output logic [tqrb_pkg::SEED_W-1:0]          seed,
    output logic                                 send_valid,
    output logic [tqrb_pkg::ADDR_W-1:0]          send_addr,
    output logic [tqrb_pkg::TYPE_W-1:0]          send_type,
    output logic [tqrb_pkg::MSG_W-1:0]           send_body,
    output logic                                 enqueue_accepted,
    output logic [tqrb_pkg::LEVEL_W-1:0]         queue_level,
    output logic                                 led_on
);

    localparam int ENTRY_W = tqrb_pkg::ADDR_W + tqrb_pkg::TYPE_W + tqrb_pkg::BODY_WIDTH;

    logic [ENTRY_W-1:0] store_mem [tqrb_pkg::QUEUE_DEPTH];

    logic [1:0]                      cmd_reg;
    logic [tqrb_pkg::ADDR_W-1:0]     addr_reg;
    logic [tqrb_pkg::TYPE_W-1:0]     type_reg;
    tqrb_pkg::body_t                 body_reg;

    tqrb_pkg::idx_t                  head_reg, head_next;
    tqrb_pkg::idx_t                  tail_reg, tail_next;
    tqrb_pkg::level_t                level_reg, level_next;
    logic                            pending_reg, pending_next;
    logic [tqrb_pkg::BO_W-1:0]       backoff_reg, backoff_next;
    logic [tqrb_pkg::LCG_W-1:0]      lcg_reg, lcg_next;
    logic                            led_reg, led_next;
    logic [tqrb_pkg::SEED_W-1:0]     seed_reg;

    logic                            sv_reg, sv_next;
    logic [tqrb_pkg::ADDR_W-1:0]     saddr_reg, saddr_next;
    logic [tqrb_pkg::TYPE_W-1:0]     stype_reg, stype_next;
    logic [tqrb_pkg::MSG_W-1:0]      sbody_reg, sbody_next;
    logic                            acc_reg, acc_next;
    tqrb_pkg::level_t                qlvl_reg;
    logic                            led_out_reg;

    logic [tqrb_pkg::LCG_W-1:0]      lcg_mul;
    logic [tqrb_pkg::LCG_W-1:0]      lcg_step;
    tqrb_pkg::idx_t                  rd_idx;
    logic [ENTRY_W-1:0]              rd_entry_reg;
    logic                            try_send;
    logic                            store_we;

    assign lcg_mul  = lcg_reg * tqrb_pkg::LCG_MUL;
    assign lcg_step = lcg_mul + tqrb_pkg::LCG_ADD;
    assign rd_idx   = (command == tqrb_pkg::CMD_DONE) ? tqrb_pkg::next_index(head_reg)
                                                       : head_reg;

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        level_next   = level_reg;
        pending_next = pending_reg;
        backoff_next = backoff_reg;
        lcg_next     = lcg_reg;
        led_next     = led_reg;
        try_send     = 1'b0;
        store_we     = 1'b0;
        acc_next     = 1'b0;
        case (cmd_reg)
            tqrb_pkg::CMD_ENQUEUE:
            begin
                if (level_reg < tqrb_pkg::LEVEL_W'(tqrb_pkg::QUEUE_DEPTH))
                begin
                    store_we   = 1'b1;
                    tail_next  = tqrb_pkg::next_index(tail_reg);
                    level_next = level_reg + 1'b1;
                    acc_next   = 1'b1;
                end
            end
            tqrb_pkg::CMD_DONE:
            begin
                if (level_reg != '0)
                begin
                    led_next     = !led_reg;
                    level_next   = level_reg - 1'b1;
                    head_next    = tqrb_pkg::next_index(head_reg);
                    pending_next = 1'b0;
                    try_send     = (level_next != '0) && (backoff_reg == '0);
                end
            end
            tqrb_pkg::CMD_TICK:
            begin
                if (level_reg != '0)
                begin
                    if (backoff_reg != '0)
                    begin
                        backoff_next = backoff_reg - 1'b1;
                    end
                    else
                    begin
                        try_send = !pending_reg;
                    end
                end
            end
            default:
            begin
                try_send = 1'b0;
            end
        endcase
        sv_next    = try_send;
        saddr_next = '0;
        stype_next = '0;
        sbody_next = '0;
        if (try_send)
        begin
            pending_next = 1'b1;
            lcg_next     = lcg_step;
            backoff_next = lcg_step[6:5];
            saddr_next   = rd_entry_reg[ENTRY_W-1 -: tqrb_pkg::ADDR_W];
            stype_next   = rd_entry_reg[tqrb_pkg::BODY_WIDTH +: tqrb_pkg::TYPE_W];
            sbody_next   = tqrb_pkg::MSG_W'(rd_entry_reg[tqrb_pkg::BODY_WIDTH-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            level_reg   <= '0;
            pending_reg <= 1'b0;
            backoff_reg <= '0;
            lcg_reg     <= '0;
            led_reg     <= 1'b0;
            seed_reg    <= '0;
        end
        else
        begin
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
                lcg_reg  <= tqrb_pkg::LCG_W'(seed_wdata);
            end
            else if (dp_cmd.execute)
            begin
                lcg_reg <= lcg_next;
            end
            if (dp_cmd.execute)
            begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                level_reg   <= level_next;
                pending_reg <= pending_next;
                backoff_reg <= backoff_next;
                led_reg     <= led_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg  <= command;
            addr_reg <= msg_addr;
            type_reg <= msg_type;
            body_reg <= tqrb_pkg::BODY_WIDTH'(msg_body);
        end
        if (dp_cmd.execute)
        begin
            sv_reg      <= sv_next;
            saddr_reg   <= saddr_next;
            stype_reg   <= stype_next;
            sbody_reg   <= sbody_next;
            acc_reg     <= acc_next;
            qlvl_reg    <= level_next;
            led_out_reg <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.execute && store_we)
        begin
            store_mem[tail_reg] <= {addr_reg, type_reg, body_reg};
        end
        if (dp_cmd.capture)
        begin
            rd_entry_reg <= store_mem[rd_idx];
        end
    end

    assign seed             = seed_reg;
    assign send_valid       = sv_reg;
    assign send_addr        = saddr_reg;
    assign send_type        = stype_reg;
    assign send_body        = sbody_reg;
    assign enqueue_accepted = acc_reg;
    assign queue_level      = qlvl_reg;
    assign led_on           = led_out_reg;

endmodule

`default_nettype wire
